/* rtl/core/htgn_pkg.sv */
// Shared types and constants for the torus grid halfedge navigator.
package htgn_pkg;

  localparam int HE_W   = 19;
  localparam int FACE_W = 17;
  localparam int EDGE_W = 18;
  localparam int VTX_W  = 16;
  localparam int CNT_W  = 9;
  localparam int LIM_W  = 21;
  localparam int PROD_W = 36;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;

  localparam logic [17:0] RECIP3 = 18'd174763;
  localparam int RECIP3_SH = 19;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [2:0] {
    SL_0 = 3'd0,
    SL_1 = 3'd1,
    SL_2 = 3'd2,
    SL_3 = 3'd3,
    SL_4 = 3'd4,
    SL_5 = 3'd5
  } slot_t;

  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
  } pos_t;

  typedef struct packed {
    logic [HE_W-1:0]   h;
    logic              err;
    logic [PROD_W-1:0] prod;
    logic [VTX_W-1:0]  cidx;
    logic [2:0]        slot;
    logic [VTX_W-1:0]  dvd;
    logic [VTX_W-1:0]  quo;
    logic [CNT_W-1:0]  rem;
    pos_t              b;
    pos_t              u;
    pos_t              d;
    pos_t              l;
    pos_t              r;
    pos_t              ru;
    pos_t              dr;
    pos_t              dru;
    logic [VTX_W-1:0]  hcell;
    logic [VTX_W-1:0]  tcell;
    logic [VTX_W-1:0]  ocell;
    logic [HE_W-1:0]   nxt;
    logic [HE_W-1:0]   prv;
    logic [HE_W-1:0]   opp;
    logic [FACE_W-1:0] face;
    logic [EDGE_W-1:0] edge_n;
  } stage_t;

endpackage

/* rtl/core/halfedge_torus_grid_navigator.sv */
// Top level: pipelined halfedge neighbor lookup on a wrapping triangle grid.
// Throughput: one item per cycle while the result is not stalled; the cell/column divider runs 4 bits per stage.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst, synchronous, high): clears all stage valid bits, rows and cols return to 16.
module halfedge_torus_grid_navigator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [18:0] halfedge,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [18:0] next_halfedge,
  output logic [18:0] prev_halfedge,
  output logic [18:0] opposite_halfedge,
  output logic [16:0] face_number,
  output logic [17:0] edge_number,
  output logic [15:0] head_vertex,
  output logic [15:0] tail_vertex,
  output logic        index_error
);

  localparam int NS = 11;
  localparam int CW = htgn_pkg::CNT_W;
  localparam int ROW_LIM = htgn_pkg::MAX_ROWS;
  localparam int COL_LIM = htgn_pkg::MAX_COLS;

  logic [CW-1:0] grid_rows;
  logic [CW-1:0] grid_cols;
  logic [CW-1:0] nr;
  logic [CW-1:0] nc;
  logic [htgn_pkg::LIM_W-1:0] limit;
  logic [17:0] area;
  logic en;
  logic [NS:1] vld;
  htgn_pkg::stage_t stg [1:NS];
  htgn_pkg::stage_t nx [1:NS];

  function automatic htgn_pkg::pos_t mv_up(htgn_pkg::pos_t p, logic [CW-1:0] rn,
                                          logic [CW-1:0] cn);
    htgn_pkg::pos_t q;
    q.row = (p.row == '0) ? rn - 1'b1 : p.row - 1'b1;
    q.col = p.col;
    if (!q.row[0]) q.col = (p.col == cn - 1'b1) ? '0 : p.col + 1'b1;
    return q;
  endfunction

  function automatic htgn_pkg::pos_t mv_dn(htgn_pkg::pos_t p, logic [CW-1:0] rn,
                                          logic [CW-1:0] cn);
    htgn_pkg::pos_t q;
    q.row = (p.row == rn - 1'b1) ? '0 : p.row + 1'b1;
    q.col = p.col;
    if (q.row[0]) q.col = (p.col == '0) ? cn - 1'b1 : p.col - 1'b1;
    return q;
  endfunction

  function automatic htgn_pkg::pos_t mv_lf(htgn_pkg::pos_t p, logic [CW-1:0] cn);
    htgn_pkg::pos_t q;
    q.row = p.row;
    q.col = (p.col == '0) ? cn - 1'b1 : p.col - 1'b1;
    return q;
  endfunction

  function automatic htgn_pkg::pos_t mv_rt(htgn_pkg::pos_t p, logic [CW-1:0] cn);
    htgn_pkg::pos_t q;
    q.row = p.row;
    q.col = (p.col == cn - 1'b1) ? '0 : p.col + 1'b1;
    return q;
  endfunction

  function automatic logic [15:0] cell_of(htgn_pkg::pos_t p, logic [CW-1:0] cn);
    logic [17:0] m;
    m = p.row * cn + {9'd0, p.col};
    return m[15:0];
  endfunction

  always_comb begin
    nr = grid_rows;
    if (grid_rows == '0) nr = 9'd1;
    else if (grid_rows > CW'(ROW_LIM)) nr = CW'(ROW_LIM);
    nc = grid_cols;
    if (grid_cols == '0) nc = 9'd1;
    else if (grid_cols > CW'(COL_LIM)) nc = CW'(COL_LIM);
  end

  assign area = nr * nc;
  assign en = !vld[NS] || out_ready;
  assign in_ready = en;

  always_comb begin
    logic [9:0]  t;
    logic [17:0] x;
    logic [17:0] c3;
    logic [17:0] e3;
    logic [18:0] c6;
    htgn_pkg::pos_t hp;
    htgn_pkg::pos_t tp;
    htgn_pkg::pos_t op;
    logic [2:0] ns;
    logic [2:0] ps;
    logic [2:0] os;

    nx[1] = '0;
    nx[1].h = halfedge;
    nx[1].prod = halfedge[18:1] * htgn_pkg::RECIP3;

    nx[2] = stg[1];
    x = stg[1].h[18:1];
    nx[2].cidx = stg[1].prod[htgn_pkg::RECIP3_SH+15:htgn_pkg::RECIP3_SH];
    c3 = {2'b00, nx[2].cidx} + {1'b0, nx[2].cidx, 1'b0};
    nx[2].slot = {2'(x - c3), stg[1].h[0]};
    nx[2].err = {2'b00, stg[1].h} >= limit;
    nx[2].dvd = nx[2].cidx;
    nx[2].quo = '0;
    nx[2].rem = '0;

    for (int k = 3; k <= 6; k++) begin
      nx[k] = stg[k-1];
      for (int j = 0; j < 4; j++) begin
        t = {nx[k].rem, nx[k].dvd[15]};
        nx[k].dvd = {nx[k].dvd[14:0], 1'b0};
        if (t >= {1'b0, nc}) begin
          t = t - {1'b0, nc};
          nx[k].quo = {nx[k].quo[14:0], 1'b1};
        end else begin
          nx[k].quo = {nx[k].quo[14:0], 1'b0};
        end
        nx[k].rem = t[8:0];
      end
    end

    nx[7] = stg[6];
    nx[7].b.row = stg[6].quo[8:0];
    nx[7].b.col = stg[6].rem;
    nx[7].u = mv_up(nx[7].b, nr, nc);
    nx[7].d = mv_dn(nx[7].b, nr, nc);
    nx[7].l = mv_lf(nx[7].b, nc);
    nx[7].r = mv_rt(nx[7].b, nc);

    nx[8] = stg[7];
    nx[8].ru = mv_rt(stg[7].u, nc);

    nx[9] = stg[8];
    nx[9].dr = mv_dn(stg[8].r, nr, nc);
    nx[9].dru = mv_dn(stg[8].ru, nr, nc);

    nx[10] = stg[9];
    case (htgn_pkg::slot_t'(stg[9].slot))
      htgn_pkg::SL_0: begin
        hp = stg[9].d;   tp = stg[9].b;   op = stg[9].l;
      end
      htgn_pkg::SL_1: begin
        hp = stg[9].dr;  tp = stg[9].d;   op = stg[9].d;
      end
      htgn_pkg::SL_2: begin
        hp = stg[9].b;   tp = stg[9].dr;  op = stg[9].b;
      end
      htgn_pkg::SL_3: begin
        hp = stg[9].dru; tp = stg[9].dr;  op = stg[9].r;
      end
      htgn_pkg::SL_4: begin
        hp = stg[9].b;   tp = stg[9].dru; op = stg[9].u;
      end
      default: begin
        hp = stg[9].dr;  tp = stg[9].b;   op = stg[9].b;
      end
    endcase
    nx[10].hcell = cell_of(hp, nc);
    nx[10].tcell = cell_of(tp, nc);
    nx[10].ocell = cell_of(op, nc);

    nx[11] = stg[10];
    case (htgn_pkg::slot_t'(stg[10].slot))
      htgn_pkg::SL_0: begin ns = 3'd1; ps = 3'd2; os = 3'd3; end
      htgn_pkg::SL_1: begin ns = 3'd2; ps = 3'd0; os = 3'd4; end
      htgn_pkg::SL_2: begin ns = 3'd0; ps = 3'd1; os = 3'd5; end
      htgn_pkg::SL_3: begin ns = 3'd4; ps = 3'd5; os = 3'd0; end
      htgn_pkg::SL_4: begin ns = 3'd5; ps = 3'd3; os = 3'd1; end
      default:        begin ns = 3'd3; ps = 3'd4; os = 3'd2; end
    endcase
    c6 = {1'b0, stg[10].cidx, 2'b00} + {2'b00, stg[10].cidx, 1'b0};
    nx[11].nxt = c6 + {16'd0, ns};
    nx[11].prv = c6 + {16'd0, ps};
    nx[11].opp = {1'b0, stg[10].ocell, 2'b00} + {2'b00, stg[10].ocell, 1'b0}
                 + {16'd0, os};
    nx[11].face = {stg[10].cidx, 1'b0} + {16'd0, (stg[10].slot >= 3'd3)};
    if (stg[10].slot < 3'd3) begin
      e3 = {2'b00, stg[10].cidx} + {1'b0, stg[10].cidx, 1'b0};
      nx[11].edge_n = e3 + {15'd0, stg[10].slot};
    end else begin
      e3 = {2'b00, stg[10].ocell} + {1'b0, stg[10].ocell, 1'b0};
      nx[11].edge_n = e3 + {15'd0, os};
    end
    if (stg[10].err) begin
      nx[11].nxt = '0;
      nx[11].prv = '0;
      nx[11].opp = '0;
      nx[11].face = '0;
      nx[11].edge_n = '0;
      nx[11].hcell = '0;
      nx[11].tcell = '0;
    end
  end

  always_ff @(posedge clk) begin
    limit <= {1'b0, area, 2'b00} + {2'b00, area, 1'b0};
    if (rst) begin
      grid_rows <= 9'd16;
      grid_cols <= 9'd16;
      vld <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          htgn_pkg::CFG_ROWS: grid_rows <= cfg_data;
          htgn_pkg::CFG_COLS: grid_cols <= cfg_data;
          default: ;
        endcase
      end
      if (en) vld <= {vld[NS-1:1], in_valid};
    end
    if (en) begin
      for (int k = 1; k <= NS; k++) stg[k] <= nx[k];
    end
  end

  assign out_valid         = vld[NS];
  assign next_halfedge     = stg[NS].nxt;
  assign prev_halfedge     = stg[NS].prv;
  assign opposite_halfedge = stg[NS].opp;
  assign face_number       = stg[NS].face;
  assign edge_number       = stg[NS].edge_n;
  assign head_vertex       = stg[NS].hcell;
  assign tail_vertex       = stg[NS].tcell;
  assign index_error       = stg[NS].err;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> next_halfedge == '0 && prev_halfedge == '0 &&
      opposite_halfedge == '0 && edge_number == '0 && head_vertex == '0 &&
      tail_vertex == '0 && face_number == '0)
    else $error("error item carries nonzero fields");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during stall");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid && vld == '0)
    else $error("valid bits not cleared by reset");

endmodule

/* dv/tb.sv */
// Testbench for the torus grid halfedge navigator: directed, random and stall tests.
module tb;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int LATENCY = 11;
  localparam int HE_W   = htgn_pkg::HE_W;
  localparam int FACE_W = htgn_pkg::FACE_W;
  localparam int EDGE_W = htgn_pkg::EDGE_W;
  localparam int VTX_W  = htgn_pkg::VTX_W;

  typedef struct {
    logic [HE_W-1:0]   nxt;
    logic [HE_W-1:0]   prv;
    logic [HE_W-1:0]   opp;
    logic [FACE_W-1:0] face;
    logic [EDGE_W-1:0] edge_n;
    logic [VTX_W-1:0]  head;
    logic [VTX_W-1:0]  tail;
    logic              err;
  } nav_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [8:0]        cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [HE_W-1:0]   halfedge;
  logic              out_valid;
  logic              out_ready;
  logic [HE_W-1:0]   next_halfedge;
  logic [HE_W-1:0]   prev_halfedge;
  logic [HE_W-1:0]   opposite_halfedge;
  logic [FACE_W-1:0] face_number;
  logic [EDGE_W-1:0] edge_number;
  logic [VTX_W-1:0]  head_vertex;
  logic [VTX_W-1:0]  tail_vertex;
  logic              index_error;

  nav_t        nav_q[$];
  logic [8:0]  rows_reg;
  logic [8:0]  cols_reg;
  bit          idle_on;
  bit          hold_req;
  int          fails;
  int          cycles;
  int          n_sent;
  int          n_checked;
  int          n_err_seen;
  int          n_cfg;

  halfedge_torus_grid_navigator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .halfedge(halfedge),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_halfedge(next_halfedge), .prev_halfedge(prev_halfedge),
    .opposite_halfedge(opposite_halfedge), .face_number(face_number),
    .edge_number(edge_number), .head_vertex(head_vertex), .tail_vertex(tail_vertex),
    .index_error(index_error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned clamp_cnt(logic [8:0] v, int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic longint unsigned tri_nxt(longint unsigned h);
    return (h / 3) * 3 + (h + 1) % 3;
  endfunction

  function automatic longint unsigned tri_prv(longint unsigned h);
    return (h / 3) * 3 + (h + 2) % 3;
  endfunction

  function automatic longint unsigned opposite_of(longint unsigned h, longint unsigned nr,
                                                  longint unsigned nc);
    longint unsigned cidx, row, col, sl;
    cidx = h / 6;
    row = cidx / nc;
    col = cidx % nc;
    sl = (h % 6 + 3) % 6;
    case (sl)
      htgn_pkg::SL_0: col = (col + 1) % nc;
      htgn_pkg::SL_1: begin
        row = (row + nr - 1) % nr;
        if (row[0] == 1'b0) col = (col + 1) % nc;
      end
      htgn_pkg::SL_3: col = (col + nc - 1) % nc;
      htgn_pkg::SL_4: begin
        row = (row + 1) % nr;
        if (row[0] == 1'b1) col = (col + nc - 1) % nc;
      end
      default: ;
    endcase
    return (nc * row + col) * 6 + sl;
  endfunction

  function automatic longint unsigned head_cell_of(longint unsigned h, longint unsigned nr,
                                                   longint unsigned nc);
    longint unsigned cur;
    cur = h;
    for (int hop = 0; hop < 4; hop++) begin
      if (cur % 6 == htgn_pkg::SL_2 || cur % 6 == htgn_pkg::SL_4) break;
      cur = opposite_of(tri_nxt(cur), nr, nc);
    end
    return cur / 6;
  endfunction

  function automatic nav_t neighbors_of(logic [HE_W-1:0] hin);
    nav_t r;
    longint unsigned nr, nc, h, opp;
    nr = clamp_cnt(rows_reg, htgn_pkg::MAX_ROWS);
    nc = clamp_cnt(cols_reg, htgn_pkg::MAX_COLS);
    h = hin;
    r = '{default: '0};
    if (h >= 6 * nr * nc) begin
      r.err = 1'b1;
      return r;
    end
    opp = opposite_of(h, nr, nc);
    r.nxt = HE_W'(tri_nxt(h));
    r.prv = HE_W'(tri_prv(h));
    r.opp = HE_W'(opp);
    r.face = FACE_W'(h / 3);
    if (h % 6 < 3) r.edge_n = EDGE_W'(3 * (h / 6) + h % 6);
    else r.edge_n = EDGE_W'(3 * (opp / 6) + opp % 6);
    r.head = VTX_W'(head_cell_of(h, nr, nc));
    r.tail = VTX_W'(head_cell_of(tri_prv(h), nr, nc));
    return r;
  endfunction

  function automatic void cmp_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("halfedge_torus_grid_navigator regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      nav_q.push_back(neighbors_of(halfedge));
      n_sent++;
    end
  end

  always @(posedge clk) begin
    nav_t e;
    if (!rst && out_valid && out_ready) begin
      if (nav_q.size() == 0) begin
        $error("result with no item outstanding");
        fails++;
      end else begin
        e = nav_q.pop_front();
        cmp_field("next_halfedge", e.nxt, next_halfedge);
        cmp_field("prev_halfedge", e.prv, prev_halfedge);
        cmp_field("opposite_halfedge", e.opp, opposite_halfedge);
        cmp_field("face_number", e.face, face_number);
        cmp_field("edge_number", e.edge_n, edge_number);
        cmp_field("head_vertex", e.head, head_vertex);
        cmp_field("tail_vertex", e.tail, tail_vertex);
        cmp_field("index_error", e.err, index_error);
        n_checked++;
        if (e.err) n_err_seen++;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [HE_W-1:0] h);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    halfedge <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (nav_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == htgn_pkg::CFG_ROWS) rows_reg = val;
    else cols_reg = val;
    n_cfg++;
  endtask

  task automatic set_grid(input logic [8:0] r, input logic [8:0] c);
    drain();
    write_reg(htgn_pkg::CFG_ROWS, r);
    write_reg(htgn_pkg::CFG_COLS, c);
  endtask

  function automatic logic [HE_W-1:0] pick_halfedge();
    longint unsigned lim;
    lim = 6 * clamp_cnt(rows_reg, htgn_pkg::MAX_ROWS) * clamp_cnt(cols_reg, htgn_pkg::MAX_COLS);
    if ($urandom_range(0, 9) < 8) return HE_W'($urandom_range(0, 32'(lim - 1)));
    return HE_W'($urandom_range(0, (1 << HE_W) - 1));
  endfunction

  task automatic test_directed();
    logic [HE_W-1:0] he_list[$];
    for (int i = 0; i < 6; i++) he_list.push_back(HE_W'(i));
    he_list.push_back(19'd1535);
    he_list.push_back(19'd1536);
    he_list.push_back(19'h7FFFF);
    he_list.push_back(19'h2AAAA);
    he_list.push_back(19'h55555);
    foreach (he_list[i]) send_item(he_list[i]);
    set_grid(9'd0, 9'd0);
    for (int i = 0; i < 7; i++) send_item(HE_W'(i));
    set_grid(9'd511, 9'd511);
    send_item(19'd393215);
    send_item(19'd393216);
    send_item(19'h7FFFF);
    set_grid(9'd3, 9'd5);
    send_item(19'd89);
    send_item(19'd4);
  endtask

  task automatic test_random();
    logic [8:0] r, c;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin r = 9'd16; c = 9'd16; end
        1: begin r = 9'd2; c = 9'd1; end
        2: begin r = 9'd256; c = 9'd256; end
        3: begin r = 9'd7; c = 9'd3; end
        4: begin r = 9'd0; c = 9'd300; end
        5: begin r = 9'd1; c = 9'd2; end
        6: begin r = 9'd256; c = 9'd4; end
        default: begin
          r = 9'($urandom_range(0, 511));
          c = 9'($urandom_range(0, 511));
          if ($urandom_range(0, 1)) begin
            r = 9'($urandom_range(1, 12));
            c = 9'($urandom_range(1, 12));
          end
        end
      endcase
      idle_on = (ph % 3 != 2);
      set_grid(r, c);
      repeat (110) send_item(pick_halfedge());
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    set_grid(9'd8, 9'd6);
    hold_req = 1'b1;
    repeat (60) send_item(pick_halfedge());
    drain();
    repeat (40) send_item(pick_halfedge());
    idle_on = 1'b1;
  endtask

  task automatic test_tail();
    set_grid(9'd10, 9'd10);
    idle_on = 1'b0;
    repeat (100) send_item(pick_halfedge());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = htgn_pkg::CFG_ROWS;
    cfg_data = '0;
    in_valid = 1'b0;
    halfedge = '0;
    rows_reg = 9'd16;
    cols_reg = 9'd16;
    idle_on = 1'b1;
    hold_req = 1'b0;
    fails = 0;
    n_sent = 0;
    n_checked = 0;
    n_err_seen = 0;
    n_cfg = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_tail();
    drain();
    $display("covered %0d items, %0d results checked (%0d out of range), %0d register writes",
             n_sent, n_checked, n_err_seen, n_cfg);
    $display("grids from 1x1 to clamped 256x256, odd row counts, long output hold");
    if (fails == 0 && nav_q.size() == 0) begin
      $display("halfedge_torus_grid_navigator regression: pass");
    end else begin
      $display("halfedge_torus_grid_navigator regression: fail");
    end
    $finish;
  end

endmodule

/* halfedge_torus_grid_navigator.f */
rtl/core/htgn_pkg.sv
rtl/core/halfedge_torus_grid_navigator.sv
dv/tb.sv
